### src/c2p_pkg.sv
package c2p_pkg;

  localparam int DATA_W = 32;
  localparam int QUOT_W = 32;
  localparam int DEN_W  = 64;
  localparam int NUM_W  = 100;

  localparam logic CFG_ROW = 1'b0;
  localparam logic CFG_COL = 1'b1;

  typedef enum logic [1:0] {
    SEL_RR,
    SEL_TT,
    SEL_RT
  } sel_t;

  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [QUOT_W-1:0] lo;
    logic [QUOT_W-1:0] q;
    logic [DEN_W-1:0]  d;
    logic              neg;
    logic              ovf;
    logic              zero;
    logic [DATA_W-1:0] byp;
  } div_item_t;

endpackage

### src/c2p_front.sv
module c2p_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [31:0]        pos_x,
  input  logic signed [31:0]        pos_y,
  input  logic signed [31:0]        tensor_xx,
  input  logic signed [31:0]        tensor_xy,
  input  logic signed [31:0]        tensor_yy,
  input  c2p_pkg::sel_t             sel,
  output logic                      out_valid,
  input  logic                      out_ready,
  output c2p_pkg::div_item_t        out_item
);

  logic [8:1] v;
  logic [9:1] en;

  logic signed [31:0] s1_x, s1_y, s1_xx, s1_xy, s1_yy;
  c2p_pkg::sel_t      s1_sel;

  logic signed [63:0] s2_a, s2_b, s2_p;
  logic signed [33:0] s2_c1, s2_c2, s2_c3;
  c2p_pkg::sel_t      s2_sel;
  logic               s2_zero;
  logic [31:0]        s2_byp;

  logic signed [63:0] s3_v1, s3_v2, s3_v3;
  logic signed [33:0] s3_c1, s3_c2, s3_c3;
  logic [63:0]        s3_d;
  logic               s3_zero;
  logic [31:0]        s3_byp;

  logic signed [65:0] s4_h1, s4_h2, s4_h3;
  logic signed [66:0] s4_l1, s4_l2, s4_l3;
  logic [63:0]        s4_d;
  logic               s4_zero;
  logic [31:0]        s4_byp;

  logic signed [97:0] s5_t1, s5_t2, s5_t3;
  logic [63:0]        s5_d;
  logic               s5_zero;
  logic [31:0]        s5_byp;

  logic signed [99:0] s6_n;
  logic [63:0]        s6_d;
  logic               s6_zero;
  logic [31:0]        s6_byp;

  logic [99:0]        s7_mag;
  logic               s7_neg;
  logic [63:0]        s7_d;
  logic               s7_zero;
  logic [31:0]        s7_byp;

  c2p_pkg::div_item_t s8_item;

  always_comb begin
    en[9] = out_ready;
    for (int k = 8; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[8];
  assign out_item  = s8_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_x   <= pos_x;
      s1_y   <= pos_y;
      s1_xx  <= tensor_xx;
      s1_xy  <= tensor_xy;
      s1_yy  <= tensor_yy;
      s1_sel <= sel;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_a    <= s1_x * s1_x;
      s2_b    <= s1_y * s1_y;
      s2_p    <= s1_x * s1_y;
      s2_sel  <= s1_sel;
      s2_zero <= (s1_x == 32'sd0) && (s1_y == 32'sd0);
      case (s1_sel)
        c2p_pkg::SEL_RR: begin
          s2_c1  <= 34'(s1_xx);
          s2_c2  <= 34'(s1_xy) <<< 1;
          s2_c3  <= 34'(s1_yy);
          s2_byp <= s1_xx;
        end
        c2p_pkg::SEL_TT: begin
          s2_c1  <= 34'(s1_xx);
          s2_c2  <= -(34'(s1_xy) <<< 1);
          s2_c3  <= 34'(s1_yy);
          s2_byp <= s1_yy;
        end
        default: begin
          s2_c1  <= 34'(s1_yy) - 34'(s1_xx);
          s2_c2  <= 34'(s1_xy);
          s2_c3  <= '0;
          s2_byp <= s1_xy;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_c1   <= s2_c1;
      s3_c2   <= s2_c2;
      s3_c3   <= s2_c3;
      s3_d    <= s2_a + s2_b;
      s3_zero <= s2_zero;
      s3_byp  <= s2_byp;
      case (s2_sel)
        c2p_pkg::SEL_RR: begin
          s3_v1 <= s2_a;
          s3_v2 <= s2_p;
          s3_v3 <= s2_b;
        end
        c2p_pkg::SEL_TT: begin
          s3_v1 <= s2_b;
          s3_v2 <= s2_p;
          s3_v3 <= s2_a;
        end
        default: begin
          s3_v1 <= s2_p;
          s3_v2 <= s2_a - s2_b;
          s3_v3 <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_h1   <= s3_c1 * $signed(s3_v1[63:32]);
      s4_h2   <= s3_c2 * $signed(s3_v2[63:32]);
      s4_h3   <= s3_c3 * $signed(s3_v3[63:32]);
      s4_l1   <= s3_c1 * $signed({1'b0, s3_v1[31:0]});
      s4_l2   <= s3_c2 * $signed({1'b0, s3_v2[31:0]});
      s4_l3   <= s3_c3 * $signed({1'b0, s3_v3[31:0]});
      s4_d    <= s3_d;
      s4_zero <= s3_zero;
      s4_byp  <= s3_byp;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_t1   <= (98'(s4_h1) <<< 32) + 98'(s4_l1);
      s5_t2   <= (98'(s4_h2) <<< 32) + 98'(s4_l2);
      s5_t3   <= (98'(s4_h3) <<< 32) + 98'(s4_l3);
      s5_d    <= s4_d;
      s5_zero <= s4_zero;
      s5_byp  <= s4_byp;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_n    <= 100'(s5_t1) + 100'(s5_t2) + 100'(s5_t3);
      s6_d    <= s5_d;
      s6_zero <= s5_zero;
      s6_byp  <= s5_byp;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_neg  <= s6_n[99];
      s7_mag  <= s6_n[99] ? 100'(-s6_n) : 100'(s6_n);
      s7_d    <= s6_d;
      s7_zero <= s6_zero;
      s7_byp  <= s6_byp;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_item.ovf  <= s7_mag[99:32] >= {4'b0, s7_d};
      s8_item.rem  <= s7_mag[95:32];
      s8_item.lo   <= s7_mag[31:0];
      s8_item.q    <= '0;
      s8_item.d    <= s7_d;
      s8_item.neg  <= s7_neg;
      s8_item.zero <= s7_zero;
      s8_item.byp  <= s7_byp;
    end
  end

endmodule

### src/c2p_div_cell.sv
module c2p_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  c2p_pkg::div_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output c2p_pkg::div_item_t out_item
);

  logic               valid;
  c2p_pkg::div_item_t item;
  c2p_pkg::div_item_t item_next;
  logic [64:0]        trial;
  logic [64:0]        diff;
  logic               ge;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_comb begin
    trial     = {in_item.rem, in_item.lo[31]};
    diff      = trial - {1'b0, in_item.d};
    ge        = !diff[64];
    item_next = in_item;
    item_next.rem = ge ? diff[63:0] : trial[63:0];
    item_next.q   = {in_item.q[30:0], ge};
    item_next.lo  = {in_item.lo[30:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      item <= item_next;
    end
  end

endmodule

### src/cartesian_to_polar_tensor_component_core.sv
// Throughput: one item per cycle while out_ready is held high; eight
// arithmetic stages feed a chain of 32 divider cells, one quotient bit per
// cell, then one rounding stage.
// Reset clears all valid flags and sets row_index and col_index to 0;
// datapath registers are not reset.
module cartesian_to_polar_tensor_component_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] tensor_xx,
  input  logic signed [31:0] tensor_xy,
  input  logic signed [31:0] tensor_yy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] polar_value
);

  localparam int NCELL = c2p_pkg::QUOT_W;

  logic               row_index;
  logic               col_index;
  c2p_pkg::sel_t      sel;

  logic               chain_valid [0:NCELL];
  logic               chain_ready [0:NCELL];
  c2p_pkg::div_item_t chain_item  [0:NCELL];

  c2p_pkg::div_item_t last;
  logic               last_ready;
  logic               rnd;
  logic [32:0]        qr;
  logic [31:0]        result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= 1'b0;
      col_index <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        c2p_pkg::CFG_ROW: row_index <= cfg_data;
        c2p_pkg::CFG_COL: col_index <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (!row_index && !col_index) sel = c2p_pkg::SEL_RR;
    else if (row_index && col_index) sel = c2p_pkg::SEL_TT;
    else sel = c2p_pkg::SEL_RT;
  end

  c2p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .tensor_xx (tensor_xx),
    .tensor_xy (tensor_xy),
    .tensor_yy (tensor_yy),
    .sel       (sel),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_item  (chain_item[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    c2p_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  assign last       = chain_item[NCELL];
  assign last_ready = !out_valid || out_ready;
  assign chain_ready[NCELL] = last_ready;

  always_comb begin
    rnd = {last.rem, 1'b0} >= {1'b0, last.d};
    qr  = {1'b0, last.q} + {32'd0, rnd};
    if (last.zero) begin
      result = last.byp;
    end else if (last.neg) begin
      if (last.ovf || qr > 33'h080000000) result = 32'h80000000;
      else result = 32'(-qr);
    end else begin
      if (last.ovf || qr > 33'h07FFFFFFF) result = 32'h7FFFFFFF;
      else result = qr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (last_ready) begin
      out_valid <= chain_valid[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (last_ready) begin
      polar_value <= $signed(result);
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage empty");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    chain_valid[NCELL] && !last.zero && !last.ovf |-> last.rem < last.d)
    else $error("divider remainder not below divisor");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

### tb/cartesian_to_polar_tensor_component_core_test.sv
`timescale 1ns / 1ps

module cartesian_to_polar_tensor_component_core_test;

  localparam int LATENCY = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] xx;
    logic signed [31:0] xy;
    logic signed [31:0] yy;
  } point_tensor_t;

  typedef struct {
    point_tensor_t pt;
    logic          known;
    logic [31:0]   value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = c2p_pkg::CFG_ROW;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] pos_x = '0;
  logic signed [31:0] pos_y = '0;
  logic signed [31:0] tensor_xx = '0;
  logic signed [31:0] tensor_xy = '0;
  logic signed [31:0] tensor_yy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] polar_value;

  logic [31:0] polar_expected[$];
  logic        row_sel = 1'b0;
  logic        col_sel = 1'b0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  cartesian_to_polar_tensor_component_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y),
    .tensor_xx(tensor_xx), .tensor_xy(tensor_xy), .tensor_yy(tensor_yy),
    .out_valid(out_valid), .out_ready(out_ready), .polar_value(polar_value)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               polar_expected.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic c2p_pkg::sel_t component_sel(logic r, logic c);
    if (!r && !c) return c2p_pkg::SEL_RR;
    if (r && c) return c2p_pkg::SEL_TT;
    return c2p_pkg::SEL_RT;
  endfunction

  // exact numerator over x^2 + y^2, rounded half away from zero, saturated
  function automatic logic [31:0] polar_component(point_tensor_t pt,
                                                  c2p_pkg::sel_t sel);
    logic signed [129:0] num;
    logic signed [129:0] den;
    logic signed [129:0] mag;
    logic signed [129:0] quo;
    logic signed [129:0] rem;
    logic signed [65:0] a;
    logic signed [65:0] b;
    logic signed [65:0] p;
    logic neg;
    if (pt.x == 0 && pt.y == 0) begin
      case (sel)
        c2p_pkg::SEL_RR: return pt.xx;
        c2p_pkg::SEL_TT: return pt.yy;
        default: return pt.xy;
      endcase
    end
    a = 66'(pt.x) * 66'(pt.x);
    b = 66'(pt.y) * 66'(pt.y);
    p = 66'(pt.x) * 66'(pt.y);
    case (sel)
      c2p_pkg::SEL_RR:
        num = 130'(pt.xx) * a + 130'sd2 * 130'(pt.xy) * p + 130'(pt.yy) * b;
      c2p_pkg::SEL_TT:
        num = 130'(pt.xx) * b - 130'sd2 * 130'(pt.xy) * p + 130'(pt.yy) * a;
      default: num = (130'(pt.yy) - 130'(pt.xx)) * p + 130'(pt.xy) * (130'(a) - 130'(b));
    endcase
    den = 130'(a) + 130'(b);
    neg = num < 0;
    mag = neg ? -num : num;
    quo = mag / den;
    rem = mag % den;
    if (rem >= den - rem) quo = quo + 1;
    if (neg) begin
      if (quo > 130'sh80000000) return 32'h80000000;
      return 32'(-quo);
    end
    if (quo > 130'sh7fffffff) return 32'h7fffffff;
    return 32'(quo);
  endfunction

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return 32'($urandom_range(0, 4)) - 32'd2;
      4: return 32'($urandom_range(0, 511)) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic point_tensor_t random_item();
    point_tensor_t pt;
    pt.x = edge_value();
    pt.y = edge_value();
    pt.xx = edge_value();
    pt.xy = edge_value();
    pt.yy = edge_value();
    if ($urandom_range(0, 19) == 0) begin
      pt.x = '0;
      pt.y = '0;
    end
    return pt;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 7);
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (polar_expected.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h", polar_value);
          mismatches++;
        end else begin
          if (polar_value !== polar_expected[0]) begin
            if (mismatches < 10)
              $display("polar_value mismatch: expected %h got %h",
                       polar_expected[0], polar_value);
            mismatches++;
          end
          void'(polar_expected.pop_front());
        end
      end
    end
  end

  task automatic write_reg(logic idx, logic val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == c2p_pkg::CFG_ROW) row_sel = val;
    else col_sel = val;
  endtask

  task automatic drain();
    while (polar_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_item(point_tensor_t pt, logic known, logic [31:0] value);
    logic [31:0] predicted;
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    predicted = polar_component(pt, component_sel(row_sel, col_sel));
    if (known && predicted !== value) begin
      if (mismatches < 10)
        $display("table row disagrees with predictor: %h vs %h", value, predicted);
      mismatches++;
    end
    pos_x <= pt.x;
    pos_y <= pt.y;
    tensor_xx <= pt.xx;
    tensor_xy <= pt.xy;
    tensor_yy <= pt.yy;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    polar_expected.push_back(predicted);
    items_sent++;
  endtask

  stim_row_t directed[$];

  function automatic stim_row_t row(logic [31:0] x, logic [31:0] y, logic [31:0] xx,
                                    logic [31:0] xy, logic [31:0] yy, logic known,
                                    logic [31:0] value);
    stim_row_t r;
    r.pt.x = x; r.pt.y = y; r.pt.xx = xx; r.pt.xy = xy; r.pt.yy = yy;
    r.known = known;
    r.value = value;
    return r;
  endfunction

  initial begin
    logic [1:0] sel_code;
    directed.push_back(row(0, 0, 32'h00030000, 32'h00050000, 32'h00070000, 1'b1,
                           32'h00030000));
    directed.push_back(row(32'h00010000, 0, 32'h00020000, 32'h00090000, 32'h00040000, 1'b1,
                           32'h00020000));
    directed.push_back(row(0, 32'h00010000, 32'h00020000, 32'h00090000, 32'h00040000, 1'b1,
                           32'h00040000));
    directed.push_back(row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                           32'h80000000, 1'b0, 0));
    directed.push_back(row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff, 1'b1, 32'h7fffffff));
    directed.push_back(row(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                           32'h7fffffff, 1'b0, 0));
    directed.push_back(row(1, 1, 1, 0, 0, 1'b1, 1));
    directed.push_back(row(1, 1, 32'hffffffff, 0, 0, 1'b1, 32'hffffffff));
    directed.push_back(row(3, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, 0));
    directed.push_back(row(32'h80000000, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b1,
                           32'h80000000));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int phase = 0; phase < 6; phase++) begin
      sel_code = 2'(phase);
      if (phase > 0) begin
        write_reg(c2p_pkg::CFG_ROW, sel_code[0]);
        write_reg(c2p_pkg::CFG_COL, phase == 5 ? 1'b0 : sel_code[1]);
      end
      foreach (directed[i])
        send_item(directed[i].pt, directed[i].known && phase == 0,
                  directed[i].value);
      calm = (phase == 2);
      for (int k = 0; k < RANDOM_ITEMS / 6; k++) begin
        send_item(random_item(), 1'b0, '0);
        if (k == 100) begin
          in_valid <= 1'b0;
          while (polar_expected.size() != 0) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
      calm = 1'b0;
      drain();
    end

    $display("sent %0d items over all four index pairs, %0d results checked",
             items_sent, results_seen);
    if (mismatches == 0 && polar_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
src/c2p_pkg.sv
src/c2p_front.sv
src/c2p_div_cell.sv
src/cartesian_to_polar_tensor_component_core.sv
tb/cartesian_to_polar_tensor_component_core_test.sv
